/* rtl/safeguarded_newton_root_search_assert.svh */
// assertion macros for the newton root search block
// include-only header, used by the top level
`ifndef SAFEGUARDED_NEWTON_ROOT_SEARCH_ASSERT_SVH
`define SAFEGUARDED_NEWTON_ROOT_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define SNR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define SNR_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SNR_ASSERT(label, clk, rst_n, prop)
`define SNR_ASSERT_RST(label, clk, prop)
`endif
`endif

/* rtl/snr_pkg.sv */
// shared types and constants for the newton root search block
// no dependencies
package snr_pkg;
  localparam int WordW = 32;
  localparam int IterW = 16;
  localparam int TolW  = 31;
  localparam logic [TolW-1:0]  TolReset = 31'd66;
  localparam logic [IterW-1:0] MaxIterReset = 16'd10000;

  localparam logic [1:0] KindEval = 2'd0;
  localparam logic [1:0] KindRoot = 2'd1;
  localparam logic [1:0] KindFail = 2'd2;

  localparam logic CfgTol = 1'b0;
  localparam logic CfgMax = 1'b1;
endpackage

/* rtl/snr_div.sv */
// restoring divider: (num * 65536) / den truncated toward zero, saturated
// one quotient bit per cycle; uses snr_pkg
module snr_div
  import snr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [WordW-1:0] num,
  input  logic signed [WordW-1:0] den,
  output logic                    busy,
  output logic                    done,
  output logic signed [WordW-1:0] quo
);
  localparam int NW = 48;
  logic [NW-1:0] n_r, n_nxt;
  logic [WordW:0] rem_r, rem_nxt;
  logic [WordW-1:0] d_r;
  logic neg_r;
  logic [5:0] cnt_r;
  logic busy_r, done_r;
  logic [WordW:0] trial;
  logic [NW-1:0] q_abs;

  assign trial = {rem_r[WordW-1:0], n_r[NW-1]} - {1'b0, d_r};
  always_comb begin
    rem_nxt = {rem_r[WordW-1:0], n_r[NW-1]};
    n_nxt   = {n_r[NW-2:0], 1'b0};
    if (!trial[WordW]) begin
      rem_nxt = trial;
      n_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {(num[WordW-1] ? 32'(-num) : 32'(num)), 16'd0};
      d_r   <= den[WordW-1] ? 32'(-den) : 32'(den);
      neg_r <= num[WordW-1] ^ den[WordW-1];
      rem_r <= '0;
    end else if (busy_r) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  // n_r holds the magnitude quotient after the last shift
  assign q_abs = n_r;
  always_comb begin
    if (neg_r) begin
      quo = (q_abs > 48'h80000000) ? 32'sh80000000 : 32'(-q_abs);
    end else begin
      quo = (q_abs > 48'h7fffffff) ? 32'sh7fffffff : 32'(q_abs);
    end
  end
  assign busy = busy_r;
  assign done = done_r;
endmodule

/* rtl/snr_mul.sv */
// registered signed 33x32 multiplier for the bracket and step-size tests
// uses snr_pkg
module snr_mul
  import snr_pkg::*;
(
  input  logic                  clk,
  input  logic signed [WordW:0] a,
  input  logic signed [WordW-1:0] b,
  output logic signed [2*WordW:0] p
);
  logic signed [2*WordW:0] p_r;
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
  assign p = p_r;
endmodule

/* rtl/safeguarded_newton_root_search.sv */
// Safeguarded Newton root search with bisection fallback.
// Usage: a start word (operation 0) carries two bracket ends; the block
// answers it and each reply in a search with exactly one result word.
// Results of kind 0 ask the outside evaluator for f (and f') at point;
// the reply is sent back as an operation 1 word. Kind 1 reports the root,
// kind 2 the iteration limit (point 0). Replies while idle give no result.
// Start, end-point and limit replies give a registered result in the cycle
// after acceptance; an iteration reply forms three registered products run
// one after another through one multiplier, then bisects, or takes a Newton
// step through the 48-step restoring divider, before it gives its result.
// One word is in work at a time: in_tready is low from acceptance until
// the result has been taken, so a stalled receiver holds the block.
// Reset (rst_n low, synchronous) returns to idle and loads tolerance 66
// and max_iterations 10000. Configuration writes only while idle.
// Depends on snr_pkg, snr_div, snr_mul and the assertion header.
`include "safeguarded_newton_root_search_assert.svh"
module safeguarded_newton_root_search
  import snr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // first_end, second_end, f_value, slope_value
  input  logic          in_tuser,   // operation
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [55:0]   out_tdata,  // point, iteration_count, bracket_warning, pad
  output logic [1:0]    out_tuser,  // kind
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [30:0]   cfg_data
);
  localparam logic [2:0] PhIdle = 3'd0, PhFirst = 3'd1, PhSecond = 3'd2,
                         PhMid = 3'd3, PhIter = 3'd4;
  localparam logic [2:0] SqIdle = 3'd0, SqM1 = 3'd1, SqM2 = 3'd2,
                         SqM3 = 3'd3, SqDec = 3'd4, SqDiv = 3'd5, SqOut = 3'd6;

  logic [TolW-1:0] tol_r;
  logic [IterW-1:0] maxit_r;
  logic [2:0] phase_r, sq_r;
  logic signed [WordW-1:0] fp_r, sp_r, flo_r, neg_r, pos_r, est_r, step_r, ostep_r;
  logic [IterW-1:0] it_r;
  logic warn_r;
  logic signed [WordW-1:0] f_r, df_r;
  logic signed [2*WordW:0] p1_r, p2_r;
  logic ovld_r;
  logic bis_r;
  logic [1:0] okind_r;
  logic signed [WordW-1:0] opt_r;

  logic signed [WordW-1:0] a_end, b_end, f_in, df_in;
  assign a_end = in_tdata[31:0];
  assign b_end = in_tdata[63:32];
  assign f_in  = in_tdata[95:64];
  assign df_in = in_tdata[127:96];

  logic acc;
  assign in_tready = !ovld_r && sq_r == SqIdle;
  assign acc = in_tvalid && in_tready;

  // shared multiplier
  logic signed [WordW:0] ma;
  logic signed [2*WordW:0] mp;
  always_comb begin
    unique case (sq_r)
      SqM1:    ma = 33'(est_r) - 33'(pos_r);
      SqM2:    ma = 33'(est_r) - 33'(neg_r);
      default: ma = 33'(ostep_r);
    endcase
  end
  snr_mul u_mul (.clk(clk), .a(ma), .b(df_r), .p(mp));

  logic dstart, dbusy;
  logic ddone;
  logic signed [WordW-1:0] dq;
  snr_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(f_r),
                 .den(df_r), .busy(dbusy), .done(ddone), .quo(dq));

  // iteration decision
  logic signed [2*WordW:0] fs;
  logic [2*WordW:0] afs, ap3;
  logic s1p, s1n, s2p, s2n, bis;
  logic signed [WordW:0] half, bis_est, nw_est;
  logic signed [WordW:0] ws;
  logic [WordW:0] wabs;
  logic signed [WordW+1:0] mid_sum;
  assign fs   = 65'(f_r) <<< 16;
  assign afs  = fs[2*WordW] ? 65'(-fs) : 65'(fs);
  assign ap3  = mp[2*WordW] ? 65'(-mp) : 65'(mp);
  assign s1p = p1_r > fs;  assign s1n = p1_r < fs;
  assign s2p = p2_r > fs;  assign s2n = p2_r < fs;
  assign bis = (df_r == 0) || (s1p && s2p) || (s1n && s2n) || ((afs << 1) > ap3);
  assign half = (33'(pos_r) - 33'(neg_r)) >>> 1;
  assign bis_est = 33'(neg_r) + half;
  assign nw_est = 33'(est_r) - 33'(dq);
  assign ws = 33'(sp_r) - 33'(fp_r);
  assign wabs = ws[WordW] ? 33'(-ws) : 33'(ws);
  assign mid_sum = 34'(fp_r) + 34'(sp_r);

  logic signed [WordW-1:0] nest;
  logic [WordW-1:0] astep;
  always_comb begin
    if (nw_est > 33'sh07fffffff) nest = 32'sh7fffffff;
    else if (nw_est < -33'sh080000000) nest = 32'sh80000000;
    else nest = nw_est[WordW-1:0];
    astep = step_r[WordW-1] ? 32'(-step_r) : 32'(step_r);
  end

  assign dstart = (sq_r == SqDec) && !bis;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TolReset; maxit_r <= MaxIterReset;
      phase_r <= PhIdle; sq_r <= SqIdle; ovld_r <= 1'b0;
      it_r <= '0; warn_r <= 1'b0;
      fp_r <= '0; sp_r <= '0; flo_r <= '0; neg_r <= '0; pos_r <= '0;
      est_r <= '0; step_r <= '0; ostep_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgTol: tol_r <= cfg_data;
          CfgMax: maxit_r <= cfg_data[IterW-1:0];
          default: ;
        endcase
      end
      if (ovld_r && out_tready) ovld_r <= 1'b0;
      if (acc) begin
        f_r <= f_in; df_r <= df_in;
        if (!in_tuser) begin
          fp_r <= a_end; sp_r <= b_end; it_r <= '0; warn_r <= 1'b0;
          phase_r <= PhFirst; okind_r <= KindEval; opt_r <= a_end; ovld_r <= 1'b1;
        end else begin
          priority case (phase_r)
            PhFirst: begin
              flo_r <= f_in; phase_r <= PhSecond;
              okind_r <= KindEval; opt_r <= sp_r; ovld_r <= 1'b1;
            end
            PhSecond: begin
              warn_r <= (flo_r > 0 && f_in > 0) || (flo_r < 0 && f_in < 0);
              ovld_r <= 1'b1;
              if (flo_r == 0) begin
                phase_r <= PhIdle; okind_r <= KindRoot; opt_r <= fp_r;
              end else if (f_in == 0) begin
                phase_r <= PhIdle; okind_r <= KindRoot; opt_r <= sp_r;
              end else begin
                if (flo_r < 0) begin neg_r <= fp_r; pos_r <= sp_r; end
                else begin pos_r <= fp_r; neg_r <= sp_r; end
                est_r <= mid_sum[WordW:1];
                // width saturates once it no longer fits 31 bits
                ostep_r <= (wabs[WordW] || wabs[WordW-1]) ? 32'sh7fffffff
                                                         : wabs[WordW-1:0];
                step_r <= (wabs[WordW] || wabs[WordW-1]) ? 32'sh7fffffff
                                                        : wabs[WordW-1:0];
                phase_r <= PhMid; okind_r <= KindEval; opt_r <= mid_sum[WordW:1];
              end
            end
            PhMid, PhIter: begin
              if (phase_r == PhIter) begin
                if (f_in < 0) neg_r <= est_r; else pos_r <= est_r;
              end
              if (it_r >= maxit_r) begin
                phase_r <= PhIdle; okind_r <= KindFail; opt_r <= '0; ovld_r <= 1'b1;
              end else begin
                it_r <= it_r + 16'd1;
                sq_r <= SqM1;
              end
            end
            default: ;
          endcase
        end
      end
      unique case (sq_r)
        SqM1: sq_r <= SqM2;
        SqM2: begin p1_r <= mp; sq_r <= SqM3; end
        SqM3: begin p2_r <= mp; sq_r <= SqDec; end
        SqDec: begin
          ostep_r <= step_r;
          bis_r <= bis;
          if (bis) begin
            step_r <= half[WordW-1:0];
            est_r <= bis_est[WordW-1:0];
            sq_r <= SqOut;
          end else begin
            sq_r <= SqDiv;
          end
        end
        SqDiv: if (ddone) begin
          step_r <= dq; est_r <= nest; sq_r <= SqOut;
        end
        SqOut: begin
          ovld_r <= 1'b1; opt_r <= est_r; sq_r <= SqIdle;
          // bisection ends when the midpoint collapses onto the low side
          if ((astep == '0) || (bis_r && est_r == neg_r) || (astep < {1'b0, tol_r})) begin
            phase_r <= PhIdle; okind_r <= KindRoot;
          end else begin
            phase_r <= PhIter; okind_r <= KindEval;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = {7'd0, warn_r, it_r, opt_r};

  `SNR_ASSERT(a_no_accept_busy, clk, rst_n, (sq_r != SqIdle) |-> !in_tready)
  `SNR_ASSERT(a_div_only_in_div, clk, rst_n, dbusy |-> (sq_r == SqDiv))
  `SNR_ASSERT(a_iter_bound, clk, rst_n, (phase_r == PhIter) |-> (it_r != 16'd0))
endmodule

/* dv/safeguarded_newton_root_search_tb.sv */
// self-checking testbench for the safeguarded newton root search block
// plays the outside evaluator with scripted functions and predicts every result word
// depends on snr_pkg and the safeguarded_newton_root_search rtl
module safeguarded_newton_root_search_tb
  import snr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OpStart = 0;
  localparam int OpReply = 1;
  localparam int CycleLimit = 2000000;
  localparam int TargetItems = 1250;

  typedef enum int {SrIdle, SrWaitFirst, SrWaitSecond, SrWaitMid, SrWaitIter} search_phase_t;

  typedef struct {
    bit       op;
    int       first_end;
    int       second_end;
    int       f_val;
    int       slope;
  } search_word_t;

  typedef struct {
    logic [1:0]  kind;
    int          point;
    logic [15:0] iters;
    bit          warn;
  } search_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [127:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [55:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we;
  logic cfg_index;
  logic [30:0] cfg_data;

  safeguarded_newton_root_search uut (.*);

  search_word_t   word_q[$];
  search_result_t result_q[$];
  int errors = 0;
  int checked = 0;
  int n_items = 0;
  int n_roots = 0;
  int n_fails = 0;
  int cycles = 0;
  bit hold_req = 0;

  // predictor state
  search_phase_t sp_phase;
  int sp_first, sp_second, sp_lowf, sp_neg, sp_pos, sp_est, sp_step, sp_old;
  int unsigned sp_iters, sp_warn;
  longint sp_tol, sp_maxit;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int cmp3(longint a, longint b);
    return a > b ? 1 : (a < b ? -1 : 0);
  endfunction

  function automatic search_result_t make_result(logic [1:0] kind, int point);
    search_result_t r;
    r.kind = kind;
    r.point = point;
    r.iters = sp_iters[15:0];
    r.warn = sp_warn[0];
    return r;
  endfunction

  function automatic search_result_t newton_iterate(int f, int df);
    longint fs, dfl;
    int s1, s2, prev_est;
    bit bis;
    fs = longint'(f) * 65536;
    dfl = df;
    if (sp_iters >= sp_maxit) begin
      sp_phase = SrIdle;
      return make_result(KindFail, 0);
    end
    sp_iters++;
    s1 = cmp3((longint'(sp_est) - sp_pos) * dfl, fs);
    s2 = cmp3((longint'(sp_est) - sp_neg) * dfl, fs);
    bis = (df == 0) || (s1 * s2 > 0) || (mag(fs) * 2 > mag(longint'(sp_old) * dfl));
    sp_old = sp_step;
    if (bis) begin
      sp_step = int'((longint'(sp_pos) - sp_neg) >>> 1);
      sp_est = int'(longint'(sp_neg) + sp_step);
      if (sp_est == sp_neg) begin
        sp_phase = SrIdle;
        return make_result(KindRoot, sp_est);
      end
    end else begin
      prev_est = sp_est;
      sp_step = sat32(fs / dfl);
      sp_est = sat32(longint'(sp_est) - sp_step);
      if (sp_est == prev_est) begin
        sp_phase = SrIdle;
        return make_result(KindRoot, sp_est);
      end
    end
    if (mag(sp_step) < sp_tol) begin
      sp_phase = SrIdle;
      return make_result(KindRoot, sp_est);
    end
    sp_phase = SrWaitIter;
    return make_result(KindEval, sp_est);
  endfunction

  // returns 1 when the word yields a result
  function automatic bit predict_search(search_word_t w, output search_result_t r);
    longint width;
    r = make_result(KindEval, 0);
    if (w.op == OpStart) begin
      sp_first = w.first_end;
      sp_second = w.second_end;
      sp_iters = 0;
      sp_warn = 0;
      sp_phase = SrWaitFirst;
      r = make_result(KindEval, sp_first);
      return 1;
    end
    case (sp_phase)
      SrWaitFirst: begin
        sp_lowf = w.f_val;
        sp_phase = SrWaitSecond;
        r = make_result(KindEval, sp_second);
        return 1;
      end
      SrWaitSecond: begin
        sp_warn = ((sp_lowf > 0 && w.f_val > 0) || (sp_lowf < 0 && w.f_val < 0)) ? 1 : 0;
        if (sp_lowf == 0) begin
          sp_phase = SrIdle;
          r = make_result(KindRoot, sp_first);
          return 1;
        end
        if (w.f_val == 0) begin
          sp_phase = SrIdle;
          r = make_result(KindRoot, sp_second);
          return 1;
        end
        if (sp_lowf < 0) begin
          sp_neg = sp_first;
          sp_pos = sp_second;
        end else begin
          sp_pos = sp_first;
          sp_neg = sp_second;
        end
        sp_est = int'((longint'(sp_first) + sp_second) >>> 1);
        width = mag(longint'(sp_second) - sp_first);
        sp_old = width > 64'sd2147483647 ? 32'h7fffffff : int'(width);
        sp_step = sp_old;
        sp_phase = SrWaitMid;
        r = make_result(KindEval, sp_est);
        return 1;
      end
      SrWaitMid: begin
        r = newton_iterate(w.f_val, w.slope);
        return 1;
      end
      SrWaitIter: begin
        if (w.f_val < 0) sp_neg = sp_est;
        else sp_pos = sp_est;
        r = newton_iterate(w.f_val, w.slope);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void queue_word(search_word_t w, output search_result_t r, output bit has);
    has = predict_search(w, r);
    word_q.push_back(w);
    n_items++;
    if (has) result_q.push_back(r);
  endfunction

  // linear function with its zero at root, gain in Q16.16
  function automatic int eval_line(int p, int root, int gain);
    return sat32((longint'(gain) * (longint'(p) - root)) >>> 16);
  endfunction

  task automatic run_search(int a, int b, int root, int gain, int max_replies, int noise_pct);
    search_word_t w;
    search_result_t r;
    bit has;
    int n;
    w = '{OpStart, a, b, $urandom, $urandom};
    queue_word(w, r, has);
    n = 0;
    while (has && r.kind == KindEval && n < max_replies) begin
      w.op = OpReply;
      w.first_end = $urandom;
      w.second_end = $urandom;
      w.f_val = ($urandom_range(0, 99) < noise_pct) ? int'($urandom) : eval_line(r.point, root, gain);
      w.slope = ($urandom_range(0, 19) == 0) ? 0 : gain;
      queue_word(w, r, has);
      n++;
    end
  endtask

  task automatic stray_reply();
    search_word_t w;
    search_result_t r;
    bit has;
    w = '{OpReply, $urandom, $urandom, $urandom, $urandom};
    queue_word(w, r, has);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgTol) sp_tol = val & 32'h7fffffff;
    else sp_maxit = val & 32'hffff;
  endtask

  task automatic drain();
    while (word_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_searches(int upto);
    int lo, hi, root, gain;
    while (n_items < upto) begin
      case ($urandom_range(0, 9))
        0: begin
          run_search($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 12), 30);
        end
        1: stray_reply();
        default: begin
          lo = $urandom_range(0, 4000000) - 2000000;
          hi = lo + $urandom_range(1, 3000000);
          root = $urandom_range(0, 9) == 0 ? lo : $urandom_range(hi - lo) + lo;
          gain = $urandom_range(1 << 12, 1 << 19);
          if ($urandom_range(0, 1)) gain = -gain;
          if ($urandom_range(0, 1)) run_search(lo, hi, root, gain, 40, 3);
          else run_search(hi, lo, root, gain, 40, 3);
        end
      endcase
    end
  endtask

  // sender
  int send_gap = 0;
  bit send_burst = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 49) == 0) send_burst = ~send_burst;
      send_gap = send_burst ? 0 : $urandom_range(0, 19);
    end else if (!in_tvalid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (word_q.size() != 0) begin
        in_tdata <= {word_q[0].slope, word_q[0].f_val, word_q[0].second_end, word_q[0].first_end};
        in_tuser <= word_q[0].op;
        in_tvalid <= 1'b1;
        void'(word_q.pop_front());
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch in %s at result %0d: got %0h expected %0h", what, checked, got, want);
  endtask

  // receiver and checker
  int recv_stall = 0;
  int hold_cnt = 0;
  bit recv_burst = 0;
  search_result_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result word", out_tdata[31:0], 0);
        end else begin
          want = result_q.pop_front();
          if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
          if (out_tdata[31:0] !== want.point) report_mismatch("point", out_tdata[31:0], want.point);
          if (out_tdata[47:32] !== want.iters)
            report_mismatch("iteration_count", out_tdata[47:32], want.iters);
          if (out_tdata[48] !== want.warn) report_mismatch("bracket_warning", out_tdata[48], want.warn);
          if (want.kind == KindRoot) n_roots++;
          if (want.kind == KindFail) n_fails++;
          checked++;
        end
        if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 19);
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgTol;
    cfg_data = '0;
    sp_phase = SrIdle;
    {sp_first, sp_second, sp_lowf, sp_neg, sp_pos, sp_est, sp_step, sp_old} = '0;
    sp_iters = 0;
    sp_warn = 0;
    sp_tol = 66;
    sp_maxit = 10000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings first
    stray_reply();
    run_search(32'h80000000, 32'h7fffffff, 12345, 1 << 16, 6, 0);
    run_search(0, 1 << 16, 0, 1 << 16, 2, 0);                  // root at first end
    run_search(-(1 << 16), 3 << 16, 3 << 16, -(1 << 15), 2, 0); // root at second end
    run_search(1 << 16, 2 << 16, -(5 << 16), 1 << 16, 3, 0);   // no sign change
    run_search(-(4 << 16), 4 << 16, 1 << 14, 3 << 16, 1, 0);   // dropped by the next start
    run_search(-(4 << 16), 4 << 16, 7777, 0, 4, 0);            // zero gain and slope, so a root at the first end
    drain();
    write_reg(CfgMax, 1);
    write_reg(CfgTol, 1);
    run_search(-(8 << 16), 9 << 16, 1000, 1 << 17, 6, 0);      // hits the iteration limit
    drain();
    write_reg(CfgMax, 65535);
    write_reg(CfgTol, 32'h7fffffff);
    run_search(-(8 << 16), 9 << 16, 1000, 1 << 17, 6, 0);
    drain();

    // random phases under several settings
    write_reg(CfgTol, 66);
    write_reg(CfgMax, 10000);
    random_searches(350);
    hold_req = 1;
    random_searches(450);
    drain();
    write_reg(CfgTol, 1);
    write_reg(CfgMax, 65535);
    random_searches(750);
    drain();
    write_reg(CfgTol, $urandom_range(1, 1 << 20));
    write_reg(CfgMax, $urandom_range(1, 6));
    random_searches(1000);
    drain();
    write_reg(CfgTol, 32'h7fffffff);
    write_reg(CfgMax, 1);
    random_searches(1080);
    drain();
    write_reg(CfgTol, $urandom_range(1, 5000));
    write_reg(CfgMax, $urandom_range(2, 30));
    random_searches(TargetItems);
    drain();

    $display("%0d words sent, %0d results checked (%0d roots, %0d limit stops)",
             n_items, checked, n_roots, n_fails);
    $display("tolerance and iteration limit swept over both extremes");
    if (errors == 0 && result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors, %0d results missing", errors, result_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/snr_pkg.sv
rtl/snr_div.sv
rtl/snr_mul.sv
rtl/safeguarded_newton_root_search.sv
dv/safeguarded_newton_root_search_tb.sv
